// ===== hw/rtl/gmi_pkg.sv =====
// Shared widths and the controller/datapath interface types.
package gmi_pkg;
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_init;
    logic div_step;
    logic reduce;
    logic mul;
    logic upd;
    logic finish;
  } gmi_cmd_t;

  typedef struct packed {
    logic zero_mod;
    logic r1_zero;
    logic div_done;
  } gmi_stat_t;
endpackage

// ===== hw/rtl/gcd_modular_inverse.sv =====
// Extended Euclidean gcd and modular inverse, top level.
// Input channel: value and modulus, one transfer per item on in_valid/in_ready.
// Output channel: gcd_result, inverse, has_inverse, zero_modulus on
// out_valid/out_ready, one result per item, in order.
// One item is in flight at a time; in_ready is high only while idle.
// A zero modulus goes straight to the result; otherwise the item runs an initial
// reduction of value by modulus and then Euclid steps, each a bit-serial
// division, a multiply and an update.
// The bit-serial divider dominates the run time.
// The result holds in its output registers until transferred; a stalled
// receiver holds the block in its done state and blocks new input.
// Reset (rst, synchronous) returns the controller to idle and drops any
// item in progress.
module gcd_modular_inverse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [gmi_pkg::WIDTH-1:0] value,
  input  logic [gmi_pkg::WIDTH-1:0] modulus,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gmi_pkg::WIDTH-1:0] gcd_result,
  output logic [gmi_pkg::WIDTH-1:0] inverse,
  output logic                      has_inverse,
  output logic                      zero_modulus
);
  import gmi_pkg::*;

  gmi_cmd_t  cmd;
  gmi_stat_t stat;

  gmi_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  gmi_datapath u_dp (
    .clk(clk), .cmd(cmd), .stat(stat), .value(value), .modulus(modulus),
    .gcd_result(gcd_result), .inverse(inverse), .has_inverse(has_inverse),
    .zero_modulus(zero_modulus)
  );
endmodule

// ===== hw/rtl/gmi_datapath.sv =====
// Datapath: remainder and coefficient registers, bit-serial divider, multiplier, result fold.
module gmi_datapath (
  input  logic                      clk,
  input  gmi_pkg::gmi_cmd_t         cmd,
  output gmi_pkg::gmi_stat_t        stat,
  input  logic [gmi_pkg::WIDTH-1:0] value,
  input  logic [gmi_pkg::WIDTH-1:0] modulus,
  output logic [gmi_pkg::WIDTH-1:0] gcd_result,
  output logic [gmi_pkg::WIDTH-1:0] inverse,
  output logic                      has_inverse,
  output logic                      zero_modulus
);
  import gmi_pkg::*;

  logic [WIDTH-1:0] r0, r1, m0, m1, modr, dvs, quo, prod;
  logic [WIDTH-1:0] rem;
  logic             n0, n1;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] fold, inv_val;
  logic             ok;

  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0 <= modulus;
      r1 <= value;
      modr <= modulus;
      m0 <= '0;
      m1 <= WIDTH'(1);
      n0 <= 1'b0;
      n1 <= 1'b0;
    end
    if (cmd.div_start) begin
      rem <= '0;
      cnt <= '0;
      quo <= cmd.div_init ? r1 : r0;
      dvs <= cmd.div_init ? r0 : r1;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.reduce) r1 <= rem;
    if (cmd.mul) prod <= WIDTH'(quo * m1);
    if (cmd.upd) begin
      r0 <= r1;
      r1 <= rem;
      m0 <= m1;
      m1 <= m0 + prod;
      n0 <= n1;
      n1 <= ~n1;
    end
    if (cmd.finish) begin
      zero_modulus <= (modr == '0);
      gcd_result   <= (modr == '0) ? '0 : r0;
      has_inverse  <= ok;
      inverse      <= inv_val;
    end
  end

  always_comb begin
    ok = (modr != '0) && (r0 == WIDTH'(1));
    fold = (m0 >= modr) ? m0 - modr : m0;
    if (!ok) inv_val = '0;
    else if (n0 && fold != '0) inv_val = modr - fold;
    else inv_val = fold;
  end

  assign stat.zero_mod = (modr == '0);
  assign stat.r1_zero  = (r1 == '0);
  assign stat.div_done = (cnt == CNT_W'(WIDTH));
endmodule

// ===== hw/rtl/gmi_controller.sv =====
// Controller: sequences reduction, Euclid steps and result transfer.
module gmi_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output gmi_pkg::gmi_cmd_t  cmd,
  input  gmi_pkg::gmi_stat_t stat
);
  import gmi_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RDIV  = 3'd2;
  localparam logic [2:0] S_LOOP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.zero_mod) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_init = 1'b1;
          state_next = S_RDIV;
        end
      end
      S_RDIV: begin
        if (stat.div_done) begin
          cmd.reduce = 1'b1;
          state_next = S_LOOP;
        end else cmd.div_step = 1'b1;
      end
      S_LOOP: begin
        if (stat.r1_zero) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.mul = 1'b1;
          state_next = S_MUL;
        end else cmd.div_step = 1'b1;
      end
      S_MUL: state_next = S_UPD;
      S_UPD: begin
        cmd.upd = 1'b1;
        state_next = S_LOOP;
      end
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
